// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file mtg_checker.sv.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define MTG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mtg_pkg.sv -----
// Shared types and constants for the MT19937 generator.
// No dependencies.
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int STATE_LEN    = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int KEY_MAX      = 16;

    localparam int ADDR_W    = $clog2(STATE_LEN + 2);
    localparam int KEY_IDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KEY_CNT_W = $clog2(KEY_MAX + 1);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h80000000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT    = 32'd1664525;
    localparam logic [31:0] MIX2_MULT    = 32'd1566083941;
    localparam logic [31:0] ARRAY_SEED   = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [1:0] {
        ACT_SEED = 2'd0,
        ACT_KEY  = 2'd1,
        ACT_GEN  = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_S1_W0, ST_S1_MUL, ST_S1_WR,
        ST_A1_RD, ST_A1_WR, ST_A1_WRAP,
        ST_A2_RD, ST_A2_WR, ST_A2_WRAP, ST_A_FIN,
        ST_T_START, ST_T_CUR, ST_T_NXT, ST_T_WR,
        ST_G_RD, ST_G_OUT, ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 wr;
        logic                 clr;
        logic [31:0]          wdata;
        logic [KEY_IDX_W-1:0] ridx;
    } key_ctrl_t;

    typedef struct packed {
        logic [KEY_CNT_W-1:0] count;
        logic                 full;
        logic [31:0]          rdata;
    } key_stat_t;

endpackage

// ----- hw/rtl/mersenne_twister_generator_unit.sv -----
// MT19937 generator top level: stream ports and output register.
// Depends on mtg_pkg, mtg_core, mtg_keybuf.
`timescale 1ns / 1ps

// One beat in gives one beat out. A generate beat reads and tempers one word while
// the 624-word state still has unread words; when it runs out, the refill is
// limited by the single read port of the state memory, since each new word needs
// two reads. Seeding from one word is limited by the one registered multiplier
// in the word-to-word chain; the final key beat runs that pass plus two mixing
// passes. Key beats that are not last and the unused action go straight to the
// result without touching the state memory. A result waits in the output
// register while the next beat is taken.
module mersenne_twister_generator_unit import mtg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // seed_value[31:0], key_word[63:32]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    input  logic        s_axis_tlast,   // key_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // random_word[31:0]
    output logic [1:0]  m_axis_tuser    // word_valid[0], key_overflow[1]
);

    key_ctrl_t   key_ctrl;
    key_stat_t   key_stat;
    logic        out_free;
    logic        res_push;
    logic [31:0] res_word;
    logic        res_wvalid;
    logic        res_ovf;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [1:0]  out_user_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    mtg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .in_seed    (s_axis_tdata[31:0]),
        .in_key     (s_axis_tdata[63:32]),
        .in_last    (s_axis_tlast),
        .out_free   (out_free),
        .res_push   (res_push),
        .res_word   (res_word),
        .res_wvalid (res_wvalid),
        .res_ovf    (res_ovf),
        .key_ctrl   (key_ctrl),
        .key_stat   (key_stat)
    );

    mtg_keybuf u_keybuf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (key_ctrl),
        .stat  (key_stat)
    );

    // Hold the output beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_word_reg <= res_word;
            out_user_reg <= {res_ovf, res_wvalid};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- hw/rtl/mtg_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/mtg_keybuf.sv -----
// Seeding key buffer with fill count.
// Depends on mtg_pkg.
`timescale 1ns / 1ps

module mtg_keybuf import mtg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  key_ctrl_t ctrl,
    output key_stat_t stat
);

    logic [31:0]          key_mem_reg [KEY_MAX];
    logic [KEY_CNT_W-1:0] count_reg;
    logic [KEY_CNT_W-1:0] count_next;
    logic                 full;

    assign full = (count_reg == KEY_CNT_W'(KEY_MAX));

    // Advance or empty the count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
        begin
            count_next = '0;
        end
        else if (ctrl.wr && !full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Store key words
    always_ff @(posedge clk)
    begin
        if (ctrl.wr && !full)
        begin
            key_mem_reg[count_reg[KEY_IDX_W-1:0]] <= ctrl.wdata;
        end
    end

    assign stat.count = count_reg;
    assign stat.full  = full;
    assign stat.rdata = key_mem_reg[ctrl.ridx];

endmodule

// ----- hw/rtl/mtg_core.sv -----
// Sequencer and datapath for seeding, refill and output of MT19937.
// Depends on mtg_pkg, mtg_ram (state memory) and mtg_keybuf (via ports).
`timescale 1ns / 1ps

module mtg_core import mtg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_action,
    input  logic [31:0] in_seed,
    input  logic [31:0] in_key,
    input  logic        in_last,
    input  logic        out_free,
    output logic        res_push,
    output logic [31:0] res_word,
    output logic        res_wvalid,
    output logic        res_ovf,
    output key_ctrl_t   key_ctrl,
    input  key_stat_t   key_stat
);

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_LEN - 1);
    localparam logic [ADDR_W-1:0] IDX_FULL  = ADDR_W'(STATE_LEN);
    localparam logic [ADDR_W-1:0] FAR_SPLIT = ADDR_W'(STATE_LEN - TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_ADD   = ADDR_W'(TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] MIX1_CNT  = ADDR_W'(STATE_LEN);
    localparam logic [ADDR_W-1:0] MIX2_CNT  = ADDR_W'(STATE_LEN - 1);
    localparam int              RAM_AW    = $clog2(STATE_LEN);

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0]    wi_reg, wi_next;
    logic [KEY_IDX_W-1:0] j_reg, j_next;
    logic [31:0]          p_reg, p_next;
    logic [31:0]          prod_reg, prod_next;
    logic [31:0]          cur_reg, cur_next;
    logic [31:0]          far_reg, far_next;
    logic [1:0]           op_reg, op_next;
    logic                 ovf_reg, ovf_next;
    logic [31:0]          word_reg, word_next;
    logic                 wvalid_reg, wvalid_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata, ram_rdata;
    logic [31:0]          mul_k, mul_x, mul_p;
    logic [31:0]          y, twisted, mixed;
    logic [ADDR_W-1:0]    idx_inc;

    function automatic logic [ADDR_W-1:0] far_of(input logic [ADDR_W-1:0] x);
        far_of = (x < FAR_SPLIT) ? x + FAR_ADD : x - FAR_SPLIT;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        temper = t ^ (t >> 18);
    endfunction

    mtg_ram #(.WIDTH(32), .DEPTH(STATE_LEN)) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[RAM_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Shared multiplier on the previous word
    assign mul_x   = p_reg ^ (p_reg >> 30);
    assign mul_p   = mul_k * mul_x;
    assign idx_inc = idx_reg + 1'b1;

    // Twist and mixing datapath
    assign y       = {cur_reg[31], ram_rdata[30:0]};
    assign twisted = far_reg ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    assign mixed   = ram_rdata ^ prod_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        wi_next     = wi_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        prod_next   = prod_reg;
        cur_next    = cur_reg;
        far_next    = far_reg;
        op_next     = op_reg;
        ovf_next    = ovf_reg;
        word_next   = word_reg;
        wvalid_next = wvalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = p_reg;
        ram_raddr   = idx_reg;
        mul_k       = SEED_MULT;
        in_ready    = 1'b0;
        res_push    = 1'b0;
        key_ctrl    = '{wr: 1'b0, clr: 1'b0, wdata: in_key, ridx: j_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_action;
                    ovf_next    = 1'b0;
                    word_next   = '0;
                    wvalid_next = 1'b0;
                    state_next  = ST_FINISH;
                    case (in_action)
                        ACT_SEED:
                        begin
                            p_next     = in_seed;
                            state_next = ST_S1_W0;
                        end
                        ACT_KEY:
                        begin
                            key_ctrl.wr = 1'b1;
                            ovf_next    = key_stat.full;
                            if (in_last)
                            begin
                                p_next     = ARRAY_SEED;
                                state_next = ST_S1_W0;
                            end
                        end
                        ACT_GEN:
                        begin
                            wvalid_next = 1'b1;
                            if (wi_reg < IDX_FULL)
                            begin
                                state_next = ST_G_RD;
                            end
                            else if (wi_reg == IDX_FULL)
                            begin
                                state_next = ST_T_START;
                            end
                            else
                            begin
                                p_next     = DEFAULT_SEED;
                                state_next = ST_S1_W0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_S1_W0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                idx_next   = ADDR_W'(1);
                state_next = ST_S1_MUL;
            end
            ST_S1_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_S1_WR;
            end
            ST_S1_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = prod_reg + 32'(idx_reg);
                p_next    = ram_wdata;
                if (idx_reg == LAST_IDX)
                begin
                    wi_next = IDX_FULL;
                    case (op_reg)
                        ACT_KEY:
                        begin
                            // mixing starts from word 0, which holds the seed
                            p_next     = ARRAY_SEED;
                            idx_next   = ADDR_W'(1);
                            j_next     = '0;
                            k_next     = MIX1_CNT;
                            state_next = ST_A1_RD;
                        end
                        ACT_GEN:  state_next = ST_T_START;
                        default:  state_next = ST_FINISH;
                    endcase
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_S1_MUL;
                end
            end
            ST_A1_RD, ST_A2_RD:
            begin
                mul_k      = (state_reg == ST_A1_RD) ? MIX1_MULT : MIX2_MULT;
                prod_next  = mul_p;
                state_next = (state_reg == ST_A1_RD) ? ST_A1_WR : ST_A2_WR;
            end
            ST_A1_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = mixed + key_stat.rdata + 32'(j_reg);
                p_next    = ram_wdata;
                k_next    = k_reg - 1'b1;
                j_next    = ((KEY_CNT_W'(j_reg) + 1'b1) == key_stat.count)
                            ? '0 : j_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_A1_WRAP;
                end
                else if (k_reg == ADDR_W'(1))
                begin
                    idx_next   = idx_inc;
                    k_next     = MIX2_CNT;
                    state_next = ST_A2_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_A1_RD;
                end
            end
            ST_A1_WRAP:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                idx_next  = ADDR_W'(1);
                if (k_reg == '0)
                begin
                    k_next     = MIX2_CNT;
                    state_next = ST_A2_RD;
                end
                else
                begin
                    state_next = ST_A1_RD;
                end
            end
            ST_A2_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = mixed - 32'(idx_reg);
                p_next    = ram_wdata;
                k_next    = k_reg - 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_A2_WRAP;
                end
                else if (k_reg == ADDR_W'(1))
                begin
                    state_next = ST_A_FIN;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_A2_RD;
                end
            end
            ST_A2_WRAP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                idx_next   = ADDR_W'(1);
                state_next = (k_reg == '0) ? ST_A_FIN : ST_A2_RD;
            end
            ST_A_FIN:
            begin
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = HIGH_BIT;
                wi_next      = IDX_FULL;
                key_ctrl.clr = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_T_START:
            begin
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = ST_T_CUR;
            end
            ST_T_CUR:
            begin
                cur_next   = ram_rdata;
                ram_raddr  = far_of(idx_reg);
                state_next = ST_T_NXT;
            end
            ST_T_NXT:
            begin
                far_next   = ram_rdata;
                ram_raddr  = (idx_reg == LAST_IDX) ? '0 : idx_inc;
                state_next = ST_T_WR;
            end
            ST_T_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = twisted;
                cur_next  = ram_rdata;
                ram_raddr = far_of(idx_inc);
                if (idx_reg == LAST_IDX)
                begin
                    wi_next    = '0;
                    state_next = ST_G_RD;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_T_NXT;
                end
            end
            ST_G_RD:
            begin
                ram_raddr  = wi_reg;
                state_next = ST_G_OUT;
            end
            ST_G_OUT:
            begin
                word_next  = temper(ram_rdata);
                wi_next    = wi_reg + 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wi_reg    <= ADDR_W'(STATE_LEN + 1);
        end
        else
        begin
            state_reg <= state_next;
            wi_reg    <= wi_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        prod_reg   <= prod_next;
        cur_reg    <= cur_next;
        far_reg    <= far_next;
        op_reg     <= op_next;
        ovf_reg    <= ovf_next;
        word_reg   <= word_next;
        wvalid_reg <= wvalid_next;
    end

    assign res_word   = word_reg;
    assign res_wvalid = wvalid_reg;
    assign res_ovf    = ovf_reg;

endmodule

// ----- hw/rtl/mtg_checker.sv -----
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled output beat holds its payload
    `MTG_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Non-generate results carry a zero word
    `MTG_ASSERT_IMP(a_zero_word, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 32'd0)

    // A beat never both generates and reports a dropped key word
    `MTG_ASSERT_IMP(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // Taking an input beat makes the block busy next cycle
    `MTG_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
